// ===== rtl/dbrsr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dbrsr_pkg
// Types, constants and the arctangent table shared by the RSR path length core.
// ----------------------------------------------------------------------------
package dbrsr_pkg;

   localparam int CORDIC_STAGES_DEFAULT = 16;

   localparam logic signed [33:0] CORDIC_SEED_Q30 = 34'sd652032874;
   localparam logic [23:0] INV_GAIN_Q24 = 24'd10188012;
   localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
   localparam logic [31:0] HALF_TURN32 = 32'h8000_0000;
   localparam logic [39:0] LEN_MAX = 40'hFF_FFFF_FFFF;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic [15:0] start_heading;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic [15:0] end_heading;
   } req_type;

   typedef struct packed {
      logic [39:0] first_arc_length;
      logic [39:0] straight_length;
      logic [39:0] second_arc_length;
      logic [39:0] path_length;
      logic [15:0] tangent_heading;
   } rsp_type;

   typedef struct packed {
      logic signed [33:0] xs;
      logic signed [33:0] ys;
      logic signed [33:0] zs;
      logic signed [33:0] xe;
      logic signed [33:0] ye;
      logic signed [33:0] ze;
   } rot_type;

   typedef struct packed {
      logic signed [43:0] x;
      logic signed [43:0] y;
      logic [31:0] z;
   } vec_type;

   typedef struct packed {
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [31:0] ex;
      logic signed [31:0] ey;
      logic [15:0] sh;
      logic [15:0] eh;
      logic flip_s;
      logic flip_e;
      logic zero;
   } side_type;

   function automatic logic [31:0] atan_val(input int idx);
      logic [31:0] v;
      case (idx)
         0: v = 32'h20000000;
         1: v = 32'h12E4051E;
         2: v = 32'h09FB385B;
         3: v = 32'h051111D4;
         4: v = 32'h028B0D43;
         5: v = 32'h0145D7E1;
         6: v = 32'h00A2F61E;
         7: v = 32'h00517C55;
         8: v = 32'h0028BE53;
         9: v = 32'h00145F2E;
         10: v = 32'h000A2F98;
         11: v = 32'h000517CC;
         12: v = 32'h00028BE6;
         13: v = 32'h000145F3;
         14: v = 32'h0000A2F9;
         15: v = 32'h0000517C;
         16: v = 32'h000028BE;
         17: v = 32'h0000145F;
         18: v = 32'h00000A2F;
         19: v = 32'h00000517;
         20: v = 32'h0000028B;
         21: v = 32'h00000145;
         22: v = 32'h000000A2;
         23: v = 32'h00000051;
         24: v = 32'h00000028;
         25: v = 32'h00000014;
         26: v = 32'h0000000A;
         27: v = 32'h00000005;
         28: v = 32'h00000002;
         29: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/dbrsr_rot_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dbrsr_rot_cell
// One rotation step for the start and end heading CORDICs, with side data.
// ----------------------------------------------------------------------------
module dbrsr_rot_cell
   import dbrsr_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic valid_in,
   input wire rot_type rot_in,
   input wire side_type side_in,
   output logic valid_out,
   output rot_type rot_out,
   output side_type side_out
);

   localparam logic signed [33:0] ATAN = 34'($signed({2'b00, atan_val(SHIFT)}));

   logic valid_ff;
   rot_type rot_ff, rot_in_w;
   side_type side_ff;

   always_comb begin
      rot_in_w = rot_in;
      if (rot_in.zs >= 0) begin
         rot_in_w.xs = rot_in.xs - (rot_in.ys >>> SHIFT);
         rot_in_w.ys = rot_in.ys + (rot_in.xs >>> SHIFT);
         rot_in_w.zs = rot_in.zs - ATAN;
      end else begin
         rot_in_w.xs = rot_in.xs + (rot_in.ys >>> SHIFT);
         rot_in_w.ys = rot_in.ys - (rot_in.xs >>> SHIFT);
         rot_in_w.zs = rot_in.zs + ATAN;
      end
      if (rot_in.ze >= 0) begin
         rot_in_w.xe = rot_in.xe - (rot_in.ye >>> SHIFT);
         rot_in_w.ye = rot_in.ye + (rot_in.xe >>> SHIFT);
         rot_in_w.ze = rot_in.ze - ATAN;
      end else begin
         rot_in_w.xe = rot_in.xe + (rot_in.ye >>> SHIFT);
         rot_in_w.ye = rot_in.ye - (rot_in.xe >>> SHIFT);
         rot_in_w.ze = rot_in.ze + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rot_ff <= rot_in_w;
      side_ff <= side_in;
   end

   assign valid_out = valid_ff;
   assign rot_out = rot_ff;
   assign side_out = side_ff;

endmodule
`default_nettype wire

// ===== rtl/dbrsr_vec_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dbrsr_vec_cell
// One vectoring step of the centre-to-centre CORDIC, with side data.
// ----------------------------------------------------------------------------
module dbrsr_vec_cell
   import dbrsr_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic valid_in,
   input wire vec_type vec_in,
   input wire side_type side_in,
   output logic valid_out,
   output vec_type vec_out,
   output side_type side_out
);

   localparam logic [31:0] ATAN = atan_val(SHIFT);

   logic valid_ff;
   vec_type vec_ff, vec_in_w;
   side_type side_ff;

   always_comb begin
      vec_in_w = vec_in;
      if (vec_in.y > 0) begin
         vec_in_w.x = vec_in.x + (vec_in.y >>> SHIFT);
         vec_in_w.y = vec_in.y - (vec_in.x >>> SHIFT);
         vec_in_w.z = vec_in.z + ATAN;
      end else begin
         vec_in_w.x = vec_in.x - (vec_in.y >>> SHIFT);
         vec_in_w.y = vec_in.y + (vec_in.x >>> SHIFT);
         vec_in_w.z = vec_in.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      vec_ff <= vec_in_w;
      side_ff <= side_in;
   end

   assign valid_out = valid_ff;
   assign vec_out = vec_ff;
   assign side_out = side_ff;

endmodule
`default_nettype wire

// ===== rtl/dubins_rsr_path_length_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dubins_rsr_path_length_core
// Right-straight-right Dubins path lengths from a start and an end pose.
// ----------------------------------------------------------------------------
// The core is fully pipelined and never busy: a pose pair may be started in
// every cycle, and its result is on the rsp_ ports for one cycle once it has
// passed the two chains of CORDIC cells (heading rotation and centre
// vectoring), the p1 to p3 stages between them and the m1 to m4 multiplier
// stages and output register behind them. The receiver cannot stall the
// results. The turning radius may only be written while no pose pair is in
// flight.
// ----------------------------------------------------------------------------
module dubins_rsr_path_length_core
   import dbrsr_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire req_type req_data,
   output logic rsp_valid,
   output rsp_type rsp_data,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [31:0] csr_data
);

   localparam int N = CORDIC_STAGES;

   logic [31:0] radius_ff;
   logic signed [32:0] radius_s;

   logic rot_valid [0:N];
   rot_type rot_st [0:N];
   side_type rot_side [0:N];
   logic vec_valid [0:N];
   vec_type vec_st [0:N];
   side_type vec_side [0:N];

   logic [31:0] ang_s, ang_e;
   side_type side0;

   logic p1_valid_ff;
   logic signed [33:0] p1_ci_ff, p1_si_ff, p1_cf_ff, p1_sf_ff;
   side_type p1_side_ff;
   logic p2_valid_ff;
   logic signed [66:0] p2_ci_ff, p2_si_ff, p2_cf_ff, p2_sf_ff;
   side_type p2_side_ff;
   logic signed [66:0] o_ci, o_si, o_cf, o_sf;
   logic signed [37:0] dx_in, dy_in;
   logic p3_valid_ff;
   logic signed [37:0] p3_dx_ff, p3_dy_ff;
   side_type p3_side_ff, side_v0;
   vec_type vec0;
   logic signed [43:0] x8, y8;

   logic m1_valid_ff;
   logic [46:0] m1_hi_ff;
   logic [44:0] m1_lo_ff;
   logic [31:0] m1_z_ff;
   side_type m1_side_ff;
   logic [68:0] mag_sum;
   logic [31:0] th_sum;
   logic [39:0] straight_in;
   logic [15:0] th_in;
   logic m2_valid_ff;
   logic [39:0] m2_st_ff;
   logic [15:0] m2_th_ff, m2_sw1_ff, m2_sw2_ff;
   logic m3_valid_ff;
   logic [39:0] m3_st_ff;
   logic [15:0] m3_th_ff;
   logic [47:0] m3_r1_ff, m3_r2_ff;
   logic [48:0] rad1_sum, rad2_sum;
   logic m4_valid_ff;
   logic [39:0] m4_st_ff;
   logic [15:0] m4_th_ff;
   logic [59:0] m4_a1_ff, m4_a2_ff;
   logic [60:0] a1_sum, a2_sum;
   logic [39:0] a1_len, a2_len;
   logic [41:0] total_sum;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 32'd65536;
      end else if (csr_valid) begin
         radius_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;
   assign busy = 1'b0;
   assign radius_s = $signed({1'b0, radius_ff});

   always_comb begin
      ang_s = {req_data.start_heading, 16'h0000};
      ang_e = {req_data.end_heading, 16'h0000};
      side0.sx = req_data.start_x;
      side0.sy = req_data.start_y;
      side0.ex = req_data.end_x;
      side0.ey = req_data.end_y;
      side0.sh = req_data.start_heading;
      side0.eh = req_data.end_heading;
      side0.flip_s = ang_s[31] ^ ang_s[30];
      side0.flip_e = ang_e[31] ^ ang_e[30];
      side0.zero = 1'b0;
      if (side0.flip_s) begin
         ang_s = ang_s ^ HALF_TURN32;
      end
      if (side0.flip_e) begin
         ang_e = ang_e ^ HALF_TURN32;
      end
      rot_st[0].xs = CORDIC_SEED_Q30;
      rot_st[0].ys = '0;
      rot_st[0].zs = 34'($signed(ang_s));
      rot_st[0].xe = CORDIC_SEED_Q30;
      rot_st[0].ye = '0;
      rot_st[0].ze = 34'($signed(ang_e));
   end

   assign rot_valid[0] = start;
   assign rot_side[0] = side0;

   for (genvar i = 0; i < N; i++) begin : g_rot
      dbrsr_rot_cell #(.SHIFT(i)) u_cell (
         .clock(clock),
         .reset(reset),
         .valid_in(rot_valid[i]),
         .rot_in(rot_st[i]),
         .side_in(rot_side[i]),
         .valid_out(rot_valid[i+1]),
         .rot_out(rot_st[i+1]),
         .side_out(rot_side[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= rot_valid[N];
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
      p1_ci_ff <= rot_side[N].flip_s ? -rot_st[N].xs : rot_st[N].xs;
      p1_si_ff <= rot_side[N].flip_s ? -rot_st[N].ys : rot_st[N].ys;
      p1_cf_ff <= rot_side[N].flip_e ? -rot_st[N].xe : rot_st[N].xe;
      p1_sf_ff <= rot_side[N].flip_e ? -rot_st[N].ye : rot_st[N].ye;
      p1_side_ff <= rot_side[N];
      p2_ci_ff <= radius_s * p1_ci_ff;
      p2_si_ff <= radius_s * p1_si_ff;
      p2_cf_ff <= radius_s * p1_cf_ff;
      p2_sf_ff <= radius_s * p1_sf_ff;
      p2_side_ff <= p1_side_ff;
      p3_dx_ff <= dx_in;
      p3_dy_ff <= dy_in;
      p3_side_ff <= p2_side_ff;
   end

   always_comb begin
      o_ci = (p2_ci_ff + 67'sd536870912) >>> 30;
      o_si = (p2_si_ff + 67'sd536870912) >>> 30;
      o_cf = (p2_cf_ff + 67'sd536870912) >>> 30;
      o_sf = (p2_sf_ff + 67'sd536870912) >>> 30;
      dx_in = (38'(p2_side_ff.ex) + o_sf[37:0]) - (38'(p2_side_ff.sx) + o_si[37:0]);
      dy_in = (38'(p2_side_ff.ey) - o_cf[37:0]) - (38'(p2_side_ff.sy) - o_ci[37:0]);
   end

   always_comb begin
      x8 = 44'(p3_dx_ff) <<< 3;
      y8 = 44'(p3_dy_ff) <<< 3;
      side_v0 = p3_side_ff;
      side_v0.zero = (p3_dx_ff == '0) && (p3_dy_ff == '0);
      if (x8 < 0) begin
         vec0.x = -x8;
         vec0.y = -y8;
         vec0.z = HALF_TURN32;
      end else begin
         vec0.x = x8;
         vec0.y = y8;
         vec0.z = '0;
      end
   end

   assign vec_valid[0] = p3_valid_ff;
   assign vec_st[0] = vec0;
   assign vec_side[0] = side_v0;

   for (genvar i = 0; i < N; i++) begin : g_vec
      dbrsr_vec_cell #(.SHIFT(i)) u_cell (
         .clock(clock),
         .reset(reset),
         .valid_in(vec_valid[i]),
         .vec_in(vec_st[i]),
         .side_in(vec_side[i]),
         .valid_out(vec_valid[i+1]),
         .vec_out(vec_st[i+1]),
         .side_out(vec_side[i+1])
      );
   end

   always_comb begin
      mag_sum = ({22'd0, m1_hi_ff} << 21) + {24'd0, m1_lo_ff} + 69'd67108864;
      th_sum = m1_z_ff + 32'h0000_8000;
      if (m1_side_ff.zero) begin
         straight_in = '0;
         th_in = '0;
      end else begin
         straight_in = (mag_sum[68:27] > {2'b00, LEN_MAX}) ? LEN_MAX : mag_sum[66:27];
         th_in = th_sum[31:16];
      end
      rad1_sum = {1'b0, m3_r1_ff} + 49'd1048576;
      rad2_sum = {1'b0, m3_r2_ff} + 49'd1048576;
      a1_sum = {1'b0, m4_a1_ff} + 61'd8388608;
      a2_sum = {1'b0, m4_a2_ff} + 61'd8388608;
      a1_len = {3'b000, a1_sum[60:24]};
      a2_len = {3'b000, a2_sum[60:24]};
      total_sum = {2'b00, a1_len} + {2'b00, m4_st_ff} + {2'b00, a2_len};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
         m4_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= vec_valid[N];
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
         m4_valid_ff <= m3_valid_ff;
         rsp_valid_ff <= m4_valid_ff;
      end
      m1_hi_ff <= 23'(vec_st[N].x[43:21]) * INV_GAIN_Q24;
      m1_lo_ff <= 21'(vec_st[N].x[20:0]) * INV_GAIN_Q24;
      m1_z_ff <= vec_st[N].z;
      m1_side_ff <= vec_side[N];
      m2_st_ff <= straight_in;
      m2_th_ff <= th_in;
      m2_sw1_ff <= m1_side_ff.sh - th_in;
      m2_sw2_ff <= th_in - m1_side_ff.eh;
      m3_st_ff <= m2_st_ff;
      m3_th_ff <= m2_th_ff;
      m3_r1_ff <= m2_sw1_ff * TWO_PI_Q29;
      m3_r2_ff <= m2_sw2_ff * TWO_PI_Q29;
      m4_st_ff <= m3_st_ff;
      m4_th_ff <= m3_th_ff;
      m4_a1_ff <= radius_ff * rad1_sum[48:21];
      m4_a2_ff <= radius_ff * rad2_sum[48:21];
      rsp_data_ff.first_arc_length <= a1_len;
      rsp_data_ff.straight_length <= m4_st_ff;
      rsp_data_ff.second_arc_length <= a2_len;
      rsp_data_ff.path_length <= (total_sum > {2'b00, LEN_MAX}) ? LEN_MAX : total_sum[39:0];
      rsp_data_ff.tangent_heading <= m4_th_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // A start transfer always enters the rotation chain.
   a_start_enters: assert property (@(posedge clock) disable iff (reset)
      start |=> rot_valid[1]) else $error("start transfer lost");

   // A result is preceded by a valid final arithmetic stage.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(m4_valid_ff)) else $error("result without transfer");

   // The total never falls below the straight segment.
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.path_length >= rsp_data.straight_length)
      else $error("total below straight length");

   // Coincident centres give a zero straight segment and heading.
   a_zero_vec: assert property (@(posedge clock) disable iff (reset)
      (m1_valid_ff && m1_side_ff.zero) |=> (m2_st_ff == '0 && m2_th_ff == '0))
      else $error("coincident centres mishandled");

endmodule
`default_nettype wire
